@@ sv/adacc_pkg.sv @@
// ----------------------------------------------------------------------------
// adacc_pkg: atom descriptor accumulator package
// Element tables, field layouts and saturation limits shared by the core.
// ----------------------------------------------------------------------------
package adacc_pkg;

	// Element table depth; element numbers at or above it have no table entry.
	localparam int ELEM_COUNT = 119;

	// Atom count limit per molecule; counters saturate at the smaller of this and 2047.
	localparam int MAX_ATOMS = 1024;
	localparam int CNT_W     = 11;
	localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'((MAX_ATOMS < 2047) ? MAX_ATOMS : 2047);

	// Saturation bounds of the wider sums.
	localparam logic signed [17:0] VAL_MIN  = -18'sd32768;
	localparam logic signed [17:0] VAL_MAX  = 18'sd65535;
	localparam logic [15:0]        RAD_MAX  = 16'd32767;
	localparam logic [14:0]        NHOH_MAX = 15'd16383;

	// Element numbers that the counters test for.
	localparam logic [6:0] Z_HYDROGEN = 7'd1;
	localparam logic [6:0] Z_CARBON   = 7'd6;
	localparam logic [6:0] Z_NITROGEN = 7'd7;
	localparam logic [6:0] Z_OXYGEN   = 7'd8;

	// Octet rule constants and the sp3 carbon degree.
	localparam logic signed [7:0] OCTET      = 8'sd8;
	localparam logic [3:0]        HALF_SHELL = 4'd4;
	localparam logic [3:0]        SP3_DEGREE = 4'd4;

	// Stream data widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 96;

	// Outer electron count per element.
	localparam logic [3:0] SHELL_E [0:ELEM_COUNT-1] = '{
		4'd0, 4'd1, 4'd2, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
		4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
		4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5,
		4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd2, 4'd3,
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd3,
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
		4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1,
		4'd2, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11,
		4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd1,
		4'd2, 4'd3, 4'd4, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
		4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2
	};

	// One when the element has a defined default valence.
	localparam logic VAL_DEF [0:ELEM_COUNT-1] = '{
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
		1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
	};

	// One atom as it arrives in tdata, last field in the lowest bits.
	typedef struct packed {
		logic              all_bonds_single;
		logic [3:0]        connection_degree;
		logic [3:0]        hydrogen_total;
		logic [3:0]        bond_valence;
		logic signed [4:0] formal_charge;
		logic [6:0]        element_number;
	} atom_t;

	// One molecule result as it leaves in tdata, last field in the lowest bits.
	typedef struct packed {
		logic [CNT_W-1:0]   sp3_carbon_count;
		logic [CNT_W-1:0]   carbon_count;
		logic [13:0]        nh_oh_hydrogen_count;
		logic [CNT_W-1:0]   nitrogen_oxygen_count;
		logic [CNT_W-1:0]   heteroatom_count;
		logic [14:0]        radical_electron_sum;
		logic signed [16:0] valence_electron_sum;
	} result_t;

	localparam int ATOM_W   = $bits(atom_t);
	localparam int RESULT_W = $bits(result_t);

endpackage

@@ sv/atom_descriptor_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// atom_descriptor_accumulator_core: per-molecule atom descriptor counter
// Sums valence and radical electrons and several atom counts over the atoms
// of one molecule and emits them, saturated, on the last atom.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata fields (low bit up)                       tuser/tlast
//  s_axis   in         element_number, formal_charge, bond_valence,    tlast = last_atom
//                      hydrogen_total, connection_degree,
//                      all_bonds_single
//  m_axis   out        valence_electron_sum, radical_electron_sum,     none
//                      heteroatom_count, nitrogen_oxygen_count,
//                      nh_oh_hydrogen_count, carbon_count,
//                      sp3_carbon_count
//
// One atom is taken per cycle. An atom is held in the input register while
// the table lookups and saturating adds fold it into the sums; a last atom
// then loads the result register, which drives the output. Only a last atom
// waiting on a full, stalled result register holds the input side. Reset
// clears the sums and both valid flags.
// ----------------------------------------------------------------------------
module atom_descriptor_accumulator_core
	import adacc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// element_number[6:0], formal_charge[11:7], bond_valence[15:12],
	// hydrogen_total[19:16], connection_degree[23:20], all_bonds_single[24]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// valence_electron_sum[16:0], radical_electron_sum[31:17],
	// heteroatom_count[42:32], nitrogen_oxygen_count[53:43],
	// nh_oh_hydrogen_count[67:54], carbon_count[78:68], sp3_carbon_count[89:79]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// Input register.
	logic  valid_s1;
	atom_t atom_s1;
	logic  last_s1;

	// Running sums.
	logic signed [16:0] valence_acc_q;
	logic [14:0]        radical_acc_q;
	logic [CNT_W-1:0]   hetero_acc_q;
	logic [CNT_W-1:0]   no_acc_q;
	logic [13:0]        nhoh_acc_q;
	logic [CNT_W-1:0]   carbon_acc_q;
	logic [CNT_W-1:0]   sp3_acc_q;

	// Result register.
	logic    out_valid_q;
	result_t out_data_q;

	// Handshake control.
	logic out_free;
	logic advance;

	// Per-atom terms.
	logic              in_table;
	logic [3:0]        shell;
	logic              val_defined;
	logic signed [7:0] shell8;
	logic signed [7:0] chg8;
	logic signed [7:0] bval8;
	logic signed [7:0] hyd8;
	logic signed [7:0] val_delta;
	logic signed [7:0] target;
	logic signed [7:0] gap;
	logic signed [7:0] free_e;
	logic [4:0]        rad_delta;
	logic              is_hetero;
	logic              is_no;
	logic              is_carbon;
	logic              is_sp3;

	// Updated sums, including the atom in the input register.
	logic signed [17:0] val_sum;
	logic [15:0]        rad_sum;
	logic [14:0]        nhoh_sum;
	result_t            upd;

	// The input register moves on unless a last atom meets a full, stalled result register.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			atom_s1 <= atom_t'(s_axis_tdata[ATOM_W-1:0]);
			last_s1 <= s_axis_tlast;
		end
	end

	// Table lookups and the electron terms of this atom.
	always_comb begin
		in_table    = atom_s1.element_number < 7'(ELEM_COUNT);
		shell       = in_table ? SHELL_E[atom_s1.element_number] : 4'd0;
		val_defined = in_table ? VAL_DEF[atom_s1.element_number] : 1'b0;
		shell8      = signed'({4'b0000, shell});
		chg8        = signed'({{3{atom_s1.formal_charge[4]}}, atom_s1.formal_charge});
		bval8       = signed'({4'b0000, atom_s1.bond_valence});
		hyd8        = signed'({4'b0000, atom_s1.hydrogen_total});

		// Hydrogen atoms do not add their own hydrogen count.
		val_delta = shell8 - chg8
			+ ((atom_s1.element_number != Z_HYDROGEN) ? hyd8 : 8'sd0);

		// Octet shortfall for elements with a default valence, odd parity otherwise; none for a zero shell count.
		target = (shell < HALF_SHELL) ? (shell8 - chg8) : (OCTET - shell8 + chg8);
		gap    = target - bval8;
		free_e = shell8 - chg8 - bval8;
		if (shell == 4'd0) begin
			rad_delta = 5'd0;
		end else if (val_defined) begin
			rad_delta = (gap > 8'sd0) ? gap[4:0] : 5'd0;
		end else begin
			rad_delta = (free_e > 8'sd0) ? {4'b0000, free_e[0]} : 5'd0;
		end

		is_hetero = (atom_s1.element_number != Z_HYDROGEN)
			&& (atom_s1.element_number != Z_CARBON);
		is_no     = (atom_s1.element_number == Z_NITROGEN)
			|| (atom_s1.element_number == Z_OXYGEN);
		is_carbon = atom_s1.element_number == Z_CARBON;
		is_sp3    = is_carbon && atom_s1.all_bonds_single
			&& (atom_s1.connection_degree == SP3_DEGREE);
	end

	// Saturating updates of every sum.
	always_comb begin
		val_sum  = {valence_acc_q[16], valence_acc_q} + {{10{val_delta[7]}}, val_delta};
		rad_sum  = {1'b0, radical_acc_q} + {11'd0, rad_delta};
		nhoh_sum = {1'b0, nhoh_acc_q} + {11'd0, atom_s1.hydrogen_total};

		if (val_sum < VAL_MIN) begin
			upd.valence_electron_sum = VAL_MIN[16:0];
		end else if (val_sum > VAL_MAX) begin
			upd.valence_electron_sum = VAL_MAX[16:0];
		end else begin
			upd.valence_electron_sum = val_sum[16:0];
		end

		upd.radical_electron_sum = (rad_sum > RAD_MAX) ? RAD_MAX[14:0] : rad_sum[14:0];

		upd.heteroatom_count = (is_hetero && hetero_acc_q < CNT_CAP)
			? hetero_acc_q + 1'b1 : hetero_acc_q;
		upd.nitrogen_oxygen_count = (is_no && no_acc_q < CNT_CAP)
			? no_acc_q + 1'b1 : no_acc_q;
		if (is_no) begin
			upd.nh_oh_hydrogen_count = (nhoh_sum > NHOH_MAX) ? NHOH_MAX[13:0] : nhoh_sum[13:0];
		end else begin
			upd.nh_oh_hydrogen_count = nhoh_acc_q;
		end
		upd.carbon_count = (is_carbon && carbon_acc_q < CNT_CAP)
			? carbon_acc_q + 1'b1 : carbon_acc_q;
		upd.sp3_carbon_count = (is_sp3 && sp3_acc_q < CNT_CAP)
			? sp3_acc_q + 1'b1 : sp3_acc_q;
	end

	// Accumulators take the updated sums, or clear after a last atom.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valence_acc_q <= '0;
			radical_acc_q <= '0;
			hetero_acc_q  <= '0;
			no_acc_q      <= '0;
			nhoh_acc_q    <= '0;
			carbon_acc_q  <= '0;
			sp3_acc_q     <= '0;
		end else if (advance) begin
			if (last_s1) begin
				valence_acc_q <= '0;
				radical_acc_q <= '0;
				hetero_acc_q  <= '0;
				no_acc_q      <= '0;
				nhoh_acc_q    <= '0;
				carbon_acc_q  <= '0;
				sp3_acc_q     <= '0;
			end else begin
				valence_acc_q <= upd.valence_electron_sum;
				radical_acc_q <= upd.radical_electron_sum;
				hetero_acc_q  <= upd.heteroatom_count;
				no_acc_q      <= upd.nitrogen_oxygen_count;
				nhoh_acc_q    <= upd.nh_oh_hydrogen_count;
				carbon_acc_q  <= upd.carbon_count;
				sp3_acc_q     <= upd.sp3_carbon_count;
			end
		end
	end

	// Result register: loaded by a last atom, emptied by an output transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_data_q <= upd;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), out_data_q};

endmodule
